[src/tfelb_pkg.sv]
// Package for the TSP forced-edge lower-bound block.
// Holds the field widths, the element type and the reset value of the node count.
// Has no dependencies; every other file of the block imports it.
package tfelb_pkg;

    localparam int WEIGHT_IN_W = 17;  // signed input weight, -1 means no edge
    localparam int BOUND_W     = 26;  // twice the bound, one fraction bit
    localparam int NODE_CNT_W  = 9;   // width of the node count register

    localparam logic [NODE_CNT_W-1:0] NODE_CNT_RESET = NODE_CNT_W'(4);

    // One matrix element as it travels from the input register to the core.
    typedef struct packed {
        logic signed [WEIGHT_IN_W-1:0] weight;
        logic                          forced;
    } t_elem;

endpackage

[src/tfelb_elem_if.sv]
// Valid/ready channel that carries one matrix element per transaction.
// Depends on tfelb_pkg for the field widths.
interface tfelb_elem_if import tfelb_pkg::*; ();
    logic                          valid;
    logic                          ready;
    logic signed [WEIGHT_IN_W-1:0] edge_weight;
    logic                          is_forced;

    modport source (output valid, output edge_weight, output is_forced, input ready);
    modport sink   (input valid, input edge_weight, input is_forced, output ready);
endinterface

[src/tfelb_bound_if.sv]
// Valid/ready channel that carries the bound result of one matrix.
// Depends on tfelb_pkg for the field widths.
interface tfelb_bound_if import tfelb_pkg::*; ();
    logic                      valid;
    logic                      ready;
    logic signed [BOUND_W-1:0] bound_twice;
    logic                      bound_valid;

    modport source (output valid, output bound_twice, output bound_valid, input ready);
    modport sink   (input valid, input bound_twice, input bound_valid, output ready);
endinterface

[src/tfelb_in_stage.sv]
// Input register of the lower-bound block: takes one element per transaction.
// Depends on tfelb_pkg and tfelb_elem_if.
module tfelb_in_stage import tfelb_pkg::*; (
    input  logic        i_clk,
    input  logic        i_rst_n,
    tfelb_elem_if.sink  i_elem,
    input  logic        i_adv,
    output logic        o_valid,
    output t_elem       o_elem
);

    logic  r_valid;
    t_elem r_elem;

    // The register is free when empty or when the core consumes it this cycle.
    assign i_elem.ready = !r_valid || i_adv;

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_valid <= 1'b0;
        end else if (i_elem.ready) begin
            r_valid <= i_elem.valid;
        end
    end

    always_ff @(posedge i_clk) begin
        if (i_elem.valid && i_elem.ready) begin
            r_elem.weight <= i_elem.edge_weight;
            r_elem.forced <= i_elem.is_forced;
        end
    end

    assign o_valid = r_valid;
    assign o_elem  = r_elem;

endmodule

[src/tfelb_core.sv]
// Row tracking, accumulation and result register of the lower-bound block.
// Depends on tfelb_pkg and tfelb_bound_if.
module tfelb_core import tfelb_pkg::*; #(
    parameter int MAX_NODES   = 256,
    parameter int WEIGHT_BITS = 16
) (
    input  logic                  i_clk,
    input  logic                  i_rst_n,
    input  logic                  i_cfg_we,
    input  logic [NODE_CNT_W-1:0] i_cfg_wdata,
    input  logic                  i_valid,
    input  t_elem                 i_elem,
    output logic                  o_adv,
    tfelb_bound_if.source         o_bound
);

    localparam int CNT_W  = $clog2(MAX_NODES);
    localparam int NW     = $clog2(MAX_NODES + 1);
    localparam int CW     = (NW > NODE_CNT_W) ? NW : NODE_CNT_W;
    // Input weights never exceed 16 bits, so storage never needs more.
    localparam int WW     = (WEIGHT_BITS < 16) ? WEIGHT_BITS : 16;
    localparam int WCAP_I = (1 << WW) - 1;

    logic [NODE_CNT_W-1:0]     r_node_count;
    logic [CNT_W-1:0]          r_col;
    logic [CNT_W-1:0]          r_row;
    logic [1:0]                r_fseen;
    logic [WW-1:0]             r_best;
    logic                      r_best_p;
    logic [WW-1:0]             r_sec;
    logic                      r_sec_p;
    logic signed [BOUND_W-1:0] r_sum;
    logic                      r_failed;
    logic                      r_out_valid;
    logic signed [BOUND_W-1:0] r_out_bound;
    logic                      r_out_ok;

    logic [1:0]                n_fseen;
    logic [WW-1:0]             n_best;
    logic                      n_best_p;
    logic [WW-1:0]             n_sec;
    logic                      n_sec_p;
    logic signed [BOUND_W-1:0] n_sum;

    logic [CW-1:0]             node_ext;
    logic [NW-1:0]             nodes_eff;
    logic                      neg;
    logic [WW-1:0]             w_sat;
    logic signed [BOUND_W-1:0] forced_add;
    logic signed [BOUND_W-1:0] row_add;
    logic                      row_fail;
    logic                      last_col;
    logic                      last_mat;

    // Clamp the node count to 1..MAX_NODES.
    always_comb begin
        node_ext = CW'(r_node_count);
        if (node_ext == '0) begin
            nodes_eff = NW'(1);
        end else if (node_ext > CW'(MAX_NODES)) begin
            nodes_eff = NW'(MAX_NODES);
        end else begin
            nodes_eff = NW'(node_ext);
        end
    end

    always_comb begin
        neg = i_elem.weight[WEIGHT_IN_W-1];
        if (i_elem.weight[15:0] > 16'(WCAP_I)) begin
            w_sat = '1;
        end else begin
            w_sat = WW'(i_elem.weight[15:0]);
        end

        n_fseen    = r_fseen;
        n_best     = r_best;
        n_best_p   = r_best_p;
        n_sec      = r_sec;
        n_sec_p    = r_sec_p;
        forced_add = '0;

        if (r_fseen != 2'd2) begin
            if (i_elem.forced) begin
                forced_add = neg ? -BOUND_W'(1) : BOUND_W'(w_sat);
                n_fseen    = r_fseen + 2'd1;
            end else if (!neg) begin
                // Keep the two smallest unforced weights of the row.
                if (!r_best_p) begin
                    n_best   = w_sat;
                    n_best_p = 1'b1;
                end else if (w_sat < r_best) begin
                    n_sec   = r_best;
                    n_sec_p = 1'b1;
                    n_best  = w_sat;
                end else if (!r_sec_p || w_sat < r_sec) begin
                    n_sec   = w_sat;
                    n_sec_p = 1'b1;
                end
            end
        end

        row_fail = (n_fseen != 2'd2 && !n_best_p) || (n_fseen == 2'd0 && !n_sec_p);
        if (row_fail || n_fseen == 2'd2) begin
            row_add = '0;
        end else if (n_fseen == 2'd0) begin
            row_add = BOUND_W'(n_best) + BOUND_W'(n_sec);
        end else begin
            row_add = BOUND_W'(n_best);
        end

        last_col = !((CNT_W + 1)'(r_col) + (CNT_W + 1)'(1) < (CNT_W + 1)'(nodes_eff));
        last_mat = last_col &&
                   !((CNT_W + 1)'(r_row) + (CNT_W + 1)'(1) < (CNT_W + 1)'(nodes_eff));
        n_sum    = r_sum + forced_add + (last_col ? row_add : BOUND_W'(0));

        // Stall only when a second result would overwrite one still waiting.
        o_adv = i_valid && !(last_mat && r_out_valid && !o_bound.ready);
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_node_count <= NODE_CNT_RESET;
        end else if (i_cfg_we) begin
            r_node_count <= i_cfg_wdata;
        end
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_col       <= '0;
            r_row       <= '0;
            r_fseen     <= '0;
            r_best      <= '0;
            r_best_p    <= 1'b0;
            r_sec       <= '0;
            r_sec_p     <= 1'b0;
            r_sum       <= '0;
            r_failed    <= 1'b0;
            r_out_valid <= 1'b0;
        end else begin
            // A new result takes priority over clearing the one just taken.
            if (o_adv && last_mat) begin
                r_out_valid <= 1'b1;
            end else if (o_bound.ready) begin
                r_out_valid <= 1'b0;
            end
            if (o_adv) begin
                if (last_col) begin
                    r_col    <= '0;
                    r_fseen  <= '0;
                    r_best   <= '0;
                    r_best_p <= 1'b0;
                    r_sec    <= '0;
                    r_sec_p  <= 1'b0;
                    if (last_mat) begin
                        r_row    <= '0;
                        r_sum    <= '0;
                        r_failed <= 1'b0;
                    end else begin
                        r_row    <= r_row + CNT_W'(1);
                        r_sum    <= n_sum;
                        r_failed <= r_failed || row_fail;
                    end
                end else begin
                    r_col    <= r_col + CNT_W'(1);
                    r_fseen  <= n_fseen;
                    r_best   <= n_best;
                    r_best_p <= n_best_p;
                    r_sec    <= n_sec;
                    r_sec_p  <= n_sec_p;
                    r_sum    <= n_sum;
                end
            end
        end
    end

    always_ff @(posedge i_clk) begin
        if (o_adv && last_mat) begin
            r_out_ok    <= !(r_failed || row_fail);
            r_out_bound <= (r_failed || row_fail) ? BOUND_W'(0) : n_sum;
        end
    end

    assign o_bound.valid       = r_out_valid;
    assign o_bound.bound_twice = r_out_bound;
    assign o_bound.bound_valid = r_out_ok;

endmodule

[src/tsp_forced_edge_lower_bound.sv]
// Top level of the TSP forced-edge lower-bound block.
// Depends on tfelb_pkg, tfelb_elem_if, tfelb_bound_if, tfelb_in_stage and tfelb_core.
//
//   Channel   Direction  Transaction carries
//   i_elem    in         one matrix element: edge_weight, is_forced (row-major order)
//   o_bound   out        one result per matrix: bound_twice, bound_valid
//   i_cfg_*   in         node_count write, taken at any edge with i_cfg_we high outside reset
//
// One element is taken every cycle while the input does not stall; an element
// waits in the input register and is folded into the row state on its way out,
// at the same edge that loads the result register, so a result shows as the
// last element of a matrix leaves the input register.
// Reset is synchronous and active low; it sets node_count to 4 and clears the
// position, the row state, the running sum and the result valid flag.
// The input stalls only when the last element of a matrix arrives while the
// previous result is still waiting to be taken on o_bound.
module tsp_forced_edge_lower_bound import tfelb_pkg::*; #(
    parameter int MAX_NODES   = 256,
    parameter int WEIGHT_BITS = 16
) (
    input  logic                  i_clk,
    input  logic                  i_rst_n,
    tfelb_elem_if.sink            i_elem,
    tfelb_bound_if.source         o_bound,
    input  logic                  i_cfg_we,
    input  logic [NODE_CNT_W-1:0] i_cfg_wdata
);

    logic  elem_valid;
    t_elem elem;
    logic  adv;

    // The input register decouples the upstream handshake from the row logic.
    tfelb_in_stage u_in_stage (
        .i_clk   (i_clk),
        .i_rst_n (i_rst_n),
        .i_elem  (i_elem),
        .i_adv   (adv),
        .o_valid (elem_valid),
        .o_elem  (elem)
    );

    // The core keeps the two smallest unforced weights and the forced count of
    // the current row, the running sum of forced weights and finished rows, and
    // the result register that holds a finished bound until it is taken.
    tfelb_core #(
        .MAX_NODES   (MAX_NODES),
        .WEIGHT_BITS (WEIGHT_BITS)
    ) u_core (
        .i_clk       (i_clk),
        .i_rst_n     (i_rst_n),
        .i_cfg_we    (i_cfg_we),
        .i_cfg_wdata (i_cfg_wdata),
        .i_valid     (elem_valid),
        .i_elem      (elem),
        .o_adv       (adv),
        .o_bound     (o_bound)
    );

endmodule
